// ===== design/sed_pkg.sv =====
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types, widths and reset values for the speech endpoint detector.
// ----------------------------------------------------------------------------
`default_nettype none

package sed_pkg;

    // field widths
    localparam int CMD_W       = 2;
    localparam int SAMPLE_W    = 16;
    localparam int LEN_W       = 19;
    localparam int QUIET_W     = 17;
    localparam int THR_W       = 15;
    localparam int MS_W        = 16;
    localparam int THR_SQ_W    = 2 * THR_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 19;

    // stream word widths, padded to whole bytes
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // parameter defaults
    localparam int SAMPLES_PER_MS_DEF = 16;
    localparam int MAX_BLOCK_DEF      = 4096;

    // register reset values
    localparam int LOUD_THRESHOLD_RST = 500;
    localparam int END_SILENCE_RST    = 800;
    localparam int MIN_SPEECH_RST     = 300;
    localparam int MAX_TURN_RST       = 320000;
    localparam int IDLE_RESTART_RST   = 32000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOUD_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_SILENCE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_RESTART   = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_START  = 2'd1,
        CMD_STOP   = 2'd2
    } t_cmd;

endpackage

`default_nettype wire

// ===== design/speech_endpoint_detector.sv =====
// ----------------------------------------------------------------------------
// speech_endpoint_detector
// Energy-based end-of-turn detection on a stream of audio samples.
// ----------------------------------------------------------------------------
// Takes one word per clock while the output is not stalled, with no gaps
// between turns or blocks. The sample is squared as its word is accepted into
// the input register. The word is then folded into the running block state
// and, on a block close or a stop, loads the result register, so a result
// passes through the input register and then the result register. The rate
// of one word per cycle is set by the combinational state update: one energy
// add, the threshold squared times count product and its compare, then the
// quiet-time add and the length compares. The squared threshold and the
// minimum turn length in samples are formed when the registers are written,
// so a register write takes effect on the next cycle. The loudness test uses
// the threshold in force when the block closes. A stalled output holds
// the input only when the pending word would produce another result.
// ----------------------------------------------------------------------------
`default_nettype none

module speech_endpoint_detector #(
    parameter int SAMPLES_PER_MS = sed_pkg::SAMPLES_PER_MS_DEF,
    parameter int MAX_BLOCK      = sed_pkg::MAX_BLOCK_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [sed_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [sed_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    input  wire logic [sed_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [15:0] sample
    input  wire logic [sed_pkg::IN_TUSER_W-1:0]    s_axis_tuser,  // [1:0] command
    input  wire logic                              s_axis_tlast,  // block_last
    // result stream
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [18:0] turn_length, [19] speech_seen, [20] block_loud, [37:21] quiet_time_ms
    output      logic [sed_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output      logic                              m_axis_tlast   // turn_over
);

    import sed_pkg::*;

    localparam int BC_W      = $clog2(MAX_BLOCK + 1);
    localparam int SUB_W     = (SAMPLES_PER_MS > 1) ? $clog2(SAMPLES_PER_MS) : 1;
    localparam int MIN_RAW_W = MS_W + $clog2(SAMPLES_PER_MS + 1);
    localparam int MIN_W     = (MIN_RAW_W > LEN_W) ? MIN_RAW_W : LEN_W + 1;
    localparam int RUN_W     = LEN_W + 1;
    localparam int DLT_W     = 32;
    localparam int ENG_W     = DLT_W + $clog2(MAX_BLOCK);
    localparam int QSUM_W    = QUIET_W + 1;

    // ---------------- configuration ----------------
    logic [THR_SQ_W-1:0] r_thr_sq;
    logic [MS_W-1:0]     r_end_silence;
    logic [MIN_W-1:0]    r_min_samples;
    logic [LEN_W-1:0]    r_max_turn;
    logic [LEN_W-1:0]    r_idle_restart;

    logic [THR_SQ_W-1:0] w_thr_sq;
    logic [MIN_W-1:0]    w_min_samples;

    assign w_thr_sq      = THR_SQ_W'(i_cfg_data[THR_W-1:0]) * THR_SQ_W'(i_cfg_data[THR_W-1:0]);
    assign w_min_samples = MIN_W'(i_cfg_data[MS_W-1:0]) * MIN_W'(SAMPLES_PER_MS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_sq       <= THR_SQ_W'(LOUD_THRESHOLD_RST * LOUD_THRESHOLD_RST);
            r_end_silence  <= MS_W'(END_SILENCE_RST);
            r_min_samples  <= MIN_W'(MIN_SPEECH_RST * SAMPLES_PER_MS);
            r_max_turn     <= LEN_W'(MAX_TURN_RST);
            r_idle_restart <= LEN_W'(IDLE_RESTART_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LOUD_THRESHOLD: r_thr_sq       <= w_thr_sq;
                REG_END_SILENCE:    r_end_silence  <= i_cfg_data[MS_W-1:0];
                REG_MIN_SPEECH:     r_min_samples  <= w_min_samples;
                REG_MAX_TURN:       r_max_turn     <= i_cfg_data[LEN_W-1:0];
                REG_IDLE_RESTART:   r_idle_restart <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register: sample squared ----------------
    logic                    r_b_valid;
    t_cmd                    r_b_cmd;
    logic                    r_b_last;
    logic [DLT_W-1:0]        r_b_sq;

    logic signed [SAMPLE_W-1:0] w_sample;
    logic signed [DLT_W-1:0]    w_sq;
    logic                       w_in_fire;
    logic                       w_c_fire;

    assign w_sample  = $signed(s_axis_tdata[SAMPLE_W-1:0]);
    assign w_sq      = DLT_W'(w_sample) * DLT_W'(w_sample);
    assign w_in_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_b_valid || w_c_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_b_valid <= 1'b1;
        end else if (w_c_fire) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_b_cmd  <= t_cmd'(s_axis_tuser[CMD_W-1:0]);
            r_b_last <= s_axis_tlast;
            r_b_sq   <= $unsigned(w_sq);
        end
    end

    // ---------------- turn state ----------------
    logic                  r_active, n_active;
    logic                  r_heard,  n_heard;
    logic [LEN_W-1:0]      r_turn,   n_turn;
    logic [RUN_W-1:0]      r_run,    n_run;     // turn length plus open block
    logic [QUIET_W-1:0]    r_quiet,  n_quiet;
    logic [ENG_W-1:0]      r_energy, n_energy;  // sum of squares of the open block
    logic [BC_W-1:0]       r_bc,     n_bc;
    logic [BC_W-1:0]       r_ms,     n_ms;      // floor(block count / samples per ms)
    logic [SUB_W-1:0]      r_sub,    n_sub;

    logic                  r_out_valid;
    logic                  r_out_over;
    logic [LEN_W-1:0]      r_out_len;
    logic                  r_out_seen;
    logic                  r_out_loud;
    logic [QUIET_W-1:0]    r_out_quiet;

    logic                  w_emit;
    logic                  w_over;
    logic [LEN_W-1:0]      w_len;
    logic                  w_loud;
    logic                  w_out_free;

    logic [ENG_W-1:0]      w_energy_new;
    logic [ENG_W-1:0]      w_limit;
    logic [BC_W-1:0]       w_bc_new;
    logic [RUN_W-1:0]      w_run_new;
    logic [BC_W-1:0]       w_ms_new;
    logic [SUB_W-1:0]      w_sub_new;
    logic                  w_close;
    logic [LEN_W-1:0]      w_samples;
    logic [QSUM_W-1:0]     w_qsum;
    logic [QUIET_W-1:0]    w_quiet_add;

    assign w_energy_new = r_energy + ENG_W'(r_b_sq);
    assign w_bc_new     = r_bc + BC_W'(1);
    // thr^2 * n against the sum of squares is exact against the floored RMS
    assign w_limit      = ENG_W'(r_thr_sq) * ENG_W'(w_bc_new);
    assign w_run_new    = r_run + RUN_W'(1);
    assign w_close      = r_b_last || (w_bc_new >= BC_W'(MAX_BLOCK))
                          || (w_run_new >= {1'b0, r_max_turn});
    assign w_qsum       = {1'b0, r_quiet} + QSUM_W'(w_ms_new);
    assign w_quiet_add  = w_qsum[QUIET_W] ? {QUIET_W{1'b1}} : w_qsum[QUIET_W-1:0];

    always_comb begin
        if (r_sub == SUB_W'(SAMPLES_PER_MS - 1)) begin
            w_sub_new = '0;
            w_ms_new  = r_ms + BC_W'(1);
        end else begin
            w_sub_new = r_sub + SUB_W'(1);
            w_ms_new  = r_ms;
        end
    end

    always_comb begin
        n_active  = r_active;
        n_heard   = r_heard;
        n_turn    = r_turn;
        n_run     = r_run;
        n_quiet   = r_quiet;
        n_energy  = r_energy;
        n_bc      = r_bc;
        n_ms      = r_ms;
        n_sub     = r_sub;
        w_emit    = 1'b0;
        w_over    = 1'b0;
        w_len     = r_turn;
        w_loud    = 1'b0;
        w_samples = w_run_new[LEN_W-1:0];

        unique case (r_b_cmd)
            CMD_START: begin
                n_active = 1'b1;
                n_heard  = 1'b0;
                n_turn   = '0;
                n_run    = '0;
                n_quiet  = '0;
                n_energy = '0;
                n_bc     = '0;
                n_ms     = '0;
                n_sub    = '0;
            end
            CMD_STOP: begin
                if (r_active) begin
                    w_emit   = 1'b1;
                    w_over   = 1'b1;
                    w_len    = (r_heard && ({{(MIN_W-LEN_W){1'b0}}, r_turn} >= r_min_samples))
                               ? r_turn : '0;
                    n_active = 1'b0;
                    n_run    = {1'b0, r_turn};   // open block dropped
                    n_energy = '0;
                    n_bc     = '0;
                    n_ms     = '0;
                    n_sub    = '0;
                end
            end
            CMD_SAMPLE: begin
                if (r_active) begin
                    if (w_close) begin
                        w_emit = 1'b1;
                        w_loud = (w_energy_new >= w_limit);
                        if (w_loud) begin
                            n_heard = 1'b1;
                            n_quiet = '0;
                        end else if (r_heard) begin
                            n_quiet = w_quiet_add;
                            w_over  = ({{(QUIET_W-MS_W){1'b0}}, r_end_silence} <= w_quiet_add);
                        end else if (w_samples > r_idle_restart) begin
                            w_samples = '0;    // idle restart before any speech
                        end
                        if (w_samples >= r_max_turn) begin
                            w_over = 1'b1;
                        end
                        n_turn   = w_samples;
                        n_run    = {1'b0, w_samples};
                        n_energy = '0;
                        n_bc     = '0;
                        n_ms     = '0;
                        n_sub    = '0;
                        if (w_over) begin
                            n_active = 1'b0;
                            w_len    = (n_heard && ({{(MIN_W-LEN_W){1'b0}}, w_samples}
                                        >= r_min_samples)) ? w_samples : '0;
                        end else begin
                            w_len    = w_samples;
                        end
                    end else begin
                        n_run    = w_run_new;
                        n_energy = w_energy_new;
                        n_bc     = w_bc_new;
                        n_ms     = w_ms_new;
                        n_sub    = w_sub_new;
                    end
                end
            end
            default: ;
        endcase
    end

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_c_fire   = r_b_valid && (!w_emit || w_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_heard  <= 1'b0;
            r_turn   <= '0;
            r_run    <= '0;
            r_quiet  <= '0;
            r_energy <= '0;
            r_bc     <= '0;
            r_ms     <= '0;
            r_sub    <= '0;
        end else if (w_c_fire) begin
            r_active <= n_active;
            r_heard  <= n_heard;
            r_turn   <= n_turn;
            r_run    <= n_run;
            r_quiet  <= n_quiet;
            r_energy <= n_energy;
            r_bc     <= n_bc;
            r_ms     <= n_ms;
            r_sub    <= n_sub;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_c_fire && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_fire && w_emit) begin
            r_out_over  <= w_over;
            r_out_len   <= w_len;
            r_out_seen  <= n_heard;
            r_out_loud  <= w_loud;
            r_out_quiet <= n_quiet;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_over;
    assign m_axis_tdata  = {{(OUT_TDATA_W-LEN_W-QUIET_W-2){1'b0}},
                            r_out_quiet, r_out_loud, r_out_seen, r_out_len};

endmodule

`default_nettype wire
